@@ rtl/bqd_pkg.sv @@
// Shared constants and types for the biquad IIR filter.
package bqd_pkg;

  localparam int DEF_SAMPLE_WIDTH  = 16;
  localparam int DEF_COEF_WIDTH    = 20;
  localparam int DEF_HISTORY_WIDTH = 20;

  localparam int NUM_COEFS = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_t;

endpackage

@@ rtl/bqd_coef_regs.sv @@
// Coefficient register file written through the configuration port.
module bqd_coef_regs
  import bqd_pkg::*;
#(
  parameter int COEF_WIDTH = DEF_COEF_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [CFG_IDX_W-1:0]         wr_index,
  input  logic [COEF_WIDTH-1:0]        wr_data,
  output logic signed [COEF_WIDTH-1:0] coef_b0,
  output logic signed [COEF_WIDTH-1:0] coef_b1,
  output logic signed [COEF_WIDTH-1:0] coef_b2,
  output logic signed [COEF_WIDTH-1:0] coef_a1,
  output logic signed [COEF_WIDTH-1:0] coef_a2
);

  localparam logic [COEF_WIDTH-1:0] B0_RESET = {2'b01, {(COEF_WIDTH-2){1'b0}}};

  logic [COEF_WIDTH-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= B0_RESET;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_B0:  b0_r <= wr_data;
        REG_B1:  b1_r <= wr_data;
        REG_B2:  b2_r <= wr_data;
        REG_A1:  a1_r <= wr_data;
        REG_A2:  a2_r <= wr_data;
        default: ;
      endcase
    end
  end

  assign coef_b0 = $signed(b0_r);
  assign coef_b1 = $signed(b1_r);
  assign coef_b2 = $signed(b2_r);
  assign coef_a1 = $signed(a1_r);
  assign coef_a2 = $signed(a2_r);

endmodule

@@ rtl/bqd_datapath.sv @@
// Multiply-accumulate, rounding, history saturation and output clipping.
module bqd_datapath
  import bqd_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = DEF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH    = DEF_COEF_WIDTH,
  parameter int HISTORY_WIDTH = DEF_HISTORY_WIDTH
) (
  input  logic signed [COEF_WIDTH-1:0]    coef_b0,
  input  logic signed [COEF_WIDTH-1:0]    coef_b1,
  input  logic signed [COEF_WIDTH-1:0]    coef_b2,
  input  logic signed [COEF_WIDTH-1:0]    coef_a1,
  input  logic signed [COEF_WIDTH-1:0]    coef_a2,
  input  logic                            restart,
  input  logic signed [SAMPLE_WIDTH-1:0]  x,
  input  logic signed [SAMPLE_WIDTH-1:0]  x1,
  input  logic signed [SAMPLE_WIDTH-1:0]  x2,
  input  logic signed [HISTORY_WIDTH-1:0] y1,
  input  logic signed [HISTORY_WIDTH-1:0] y2,
  output logic signed [HISTORY_WIDTH-1:0] y_hist,
  output logic signed [SAMPLE_WIDTH-1:0]  sample_out,
  output logic                            clipped
);

  localparam int FRAC    = COEF_WIDTH - 2;
  localparam int PX_W    = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int PY_W    = COEF_WIDTH + HISTORY_WIDTH;
  localparam int FULL_W  = ((PX_W > PY_W) ? PX_W : PY_W) + 3;
  localparam int ACC_W   = (FULL_W > 64) ? 64 : FULL_W;
  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0]  x1_m, x2_m;
  logic signed [HISTORY_WIDTH-1:0] y1_m, y2_m;
  logic signed [PX_W-1:0]          p_b0, p_b1, p_b2;
  logic signed [PY_W-1:0]          p_a1, p_a2;
  logic signed [ACC_W-1:0]         acc;
  logic signed [ACC_W-1:0]         acc_sh;
  logic                            hist_fits;

  assign x1_m = restart ? '0 : x1;
  assign x2_m = restart ? '0 : x2;
  assign y1_m = restart ? '0 : y1;
  assign y2_m = restart ? '0 : y2;

  assign p_b0 = coef_b0 * x;
  assign p_b1 = coef_b1 * x1_m;
  assign p_b2 = coef_b2 * x2_m;
  assign p_a1 = coef_a1 * y1_m;
  assign p_a2 = coef_a2 * y2_m;

  assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
             - ACC_W'(p_a1) - ACC_W'(p_a2) + HALF;
  assign acc_sh = acc >>> FRAC;

  assign hist_fits = (&acc_sh[ACC_W-1:HISTORY_WIDTH-1]) ||
                     (~|acc_sh[ACC_W-1:HISTORY_WIDTH-1]);
  assign y_hist = hist_fits ? acc_sh[HISTORY_WIDTH-1:0] :
                  {acc_sh[ACC_W-1], {(HISTORY_WIDTH-1){~acc_sh[ACC_W-1]}}};

  generate
    if (HISTORY_WIDTH > SAMPLE_WIDTH) begin : g_clip
      logic out_fits;
      assign out_fits = (&y_hist[HISTORY_WIDTH-1:SAMPLE_WIDTH-1]) ||
                        (~|y_hist[HISTORY_WIDTH-1:SAMPLE_WIDTH-1]);
      assign sample_out = out_fits ? y_hist[SAMPLE_WIDTH-1:0] :
                          {y_hist[HISTORY_WIDTH-1],
                           {(SAMPLE_WIDTH-1){~y_hist[HISTORY_WIDTH-1]}}};
      assign clipped = ~out_fits;
    end else begin : g_noclip
      assign sample_out = SAMPLE_WIDTH'(y_hist);
      assign clipped    = 1'b0;
    end
  endgenerate

endmodule

@@ rtl/biquad_iir_filter.sv @@
// Biquad IIR filter top level: input register, history, result register.
// A sample goes from the input register through the datapath to the result
// register. Throughput: one sample per cycle while out_stall does not hold a
// full result register, set by the single multiply-accumulate pass.
// Reset (synchronous, active low) empties both stages, zeroes the history
// and loads the coefficients with b0 = 1.0 and all others 0.
module biquad_iir_filter
  import bqd_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = DEF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH    = DEF_COEF_WIDTH,
  parameter int HISTORY_WIDTH = DEF_HISTORY_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  output logic                           out_clipped,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [COEF_WIDTH-1:0]          cfg_data
);

  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [COEF_WIDTH-1:0]    coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic                            s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0]  s1_sample_r;
  logic                            s1_restart_r;
  logic signed [SAMPLE_WIDTH-1:0]  x1_r, x2_r;
  logic signed [HISTORY_WIDTH-1:0] y1_r, y2_r;
  logic                            out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0]  out_sample_r;
  logic                            out_clipped_r;
  logic signed [HISTORY_WIDTH-1:0] y_hist;
  logic signed [SAMPLE_WIDTH-1:0]  y_sample;
  logic                            y_clipped;
  logic                            take;
  logic                            fire;
  logic                            accept;

  assign cfg_ready = 1'b1;

  bqd_coef_regs #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_coef_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .coef_b0  (coef_b0),
    .coef_b1  (coef_b1),
    .coef_b2  (coef_b2),
    .coef_a1  (coef_a1),
    .coef_a2  (coef_a2)
  );

  bqd_datapath #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COEF_WIDTH    (COEF_WIDTH),
    .HISTORY_WIDTH (HISTORY_WIDTH)
  ) u_datapath (
    .coef_b0    (coef_b0),
    .coef_b1    (coef_b1),
    .coef_b2    (coef_b2),
    .coef_a1    (coef_a1),
    .coef_a2    (coef_a2),
    .restart    (s1_restart_r),
    .x          (s1_sample_r),
    .x1         (x1_r),
    .x2         (x2_r),
    .y1         (y1_r),
    .y2         (y2_r),
    .y_hist     (y_hist),
    .sample_out (y_sample),
    .clipped    (y_clipped)
  );

  assign take     = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && take;
  assign in_stall = s1_valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = accept || (s1_valid_r && !fire);
    out_valid_nxt = fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        x2_r <= s1_restart_r ? '0 : x1_r;
        x1_r <= s1_sample_r;
        y2_r <= s1_restart_r ? '0 : y1_r;
        y1_r <= y_hist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r  <= in_sample_in;
      s1_restart_r <= in_restart;
    end
    if (fire) begin
      out_sample_r  <= y_sample;
      out_clipped_r <= y_clipped;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while a stage is empty");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_restart_r) |=> (x2_r == '0 && y2_r == '0))
    else $error("restart did not clear the second history taps");

  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !fire) |=> ($stable(x1_r) && $stable(y1_r)))
    else $error("history changed without a transfer into the result stage");

  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_clipped_r) |-> (out_sample_r == SMAX || out_sample_r == SMIN))
    else $error("clipped result is not at a range limit");
`endif

endmodule
